// ----- src/beam_altitude_interpolator_core_macros.svh -----
// assertion macros used by the port checker of the altitude interpolator
`ifndef BEAM_ALTITUDE_INTERPOLATOR_CORE_MACROS_SVH
`define BEAM_ALTITUDE_INTERPOLATOR_CORE_MACROS_SVH

// property that must hold at every clock edge out of reset
`define BAI_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition that must never be seen at a clock edge out of reset
`define BAI_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	`BAI_ASSERT_CLK(lbl, clk, rst_n, !(cond), msg)

`endif

// ----- src/bai_pkg.sv -----
// types and constants of the beam altitude interpolator
package bai_pkg;

	// command codes of an input word
	typedef enum logic [1:0] {
		CMD_LOAD  = 2'd0,
		CMD_QUERY = 2'd1,
		CMD_GEN   = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	// configuration register indexes
	localparam logic [1:0] CFG_BEAM_COUNT   = 2'd0;
	localparam logic [1:0] CFG_OUTPUT_BEAMS = 2'd1;
	localparam logic [1:0] CFG_PRESERVE     = 2'd2;
	localparam logic [1:0] CFG_TOLERANCE    = 2'd3;

	// configuration reset values
	localparam logic [5:0]  RST_BEAM_COUNT   = 6'd32;
	localparam logic [10:0] RST_OUTPUT_BEAMS = 11'd128;
	localparam logic        RST_PRESERVE     = 1'b1;
	localparam logic [14:0] RST_TOLERANCE    = 15'd29;

	// q1.16 weight constants
	localparam logic [16:0] WEIGHT_ZERO = 17'd0;
	localparam logic [16:0] WEIGHT_HALF = 17'd32768;
	localparam logic [16:0] WEIGHT_ONE  = 17'd65536;

	// divider step counts
	localparam logic [5:0] DIV_STEPS_WT  = 6'd16;
	localparam logic [5:0] DIV_STEPS_GEN = 6'd28;

	// table read address selection
	typedef enum logic [2:0] {
		RD_FIRST,
		RD_LAST,
		RD_SCAN,
		RD_LO,
		RD_HI
	} rd_sel_t;

	// controller states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_G_RD0,
		ST_G_RD1,
		ST_G_RANGE,
		ST_G_CHK,
		ST_G_DIV,
		ST_G_WAIT,
		ST_SCAN,
		ST_FLUSH,
		ST_BRK,
		ST_RD_LO,
		ST_RD_HI,
		ST_WT_PREP,
		ST_WT_CHK,
		ST_WT_DIV,
		ST_OUT
	} state_t;

	// commands from controller to datapath
	typedef struct packed {
		logic    cap_in;
		rd_sel_t rd_sel;
		logic    cap_first;
		logic    calc_range;
		logic    mul_go;
		logic    gen_div_go;
		logic    set_gen_tgt;
		logic    scan_init;
		logic    scan_step;
		logic    brk;
		logic    cap_tl;
		logic    wt_prep;
		logic    wt_eval;
		logic    wt_div_done;
		logic    emit;
		logic    emit_bad;
	} dp_ctl_t;

	// status from datapath to controller
	typedef struct packed {
		logic gen_bad;
		logic scan_last;
		logic div_done;
		logic wt_need_div;
	} dp_stat_t;

endpackage

// ----- src/bai_div.sv -----
// restoring divider, one quotient bit per cycle
module bai_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [15:0] rem_init,
	input  logic [31:0] dividend,
	input  logic [15:0] divisor,
	input  logic [5:0]  steps,
	output logic        done,
	output logic [31:0] quotient
);

	logic        run_q;
	logic        done_q;
	logic [5:0]  cnt_q;
	logic [15:0] rem_q;
	logic [31:0] dvd_q;
	logic [31:0] quo_q;
	logic [15:0] dsr_q;
	logic [16:0] trial;
	logic [16:0] diff;
	logic        fits;

	// trial subtract of the divisor from the shifted remainder
	always_comb begin
		trial = {rem_q, dvd_q[31]};
		diff  = trial - {1'b0, dsr_q};
		fits  = trial >= {1'b0, dsr_q};
	end

	// control of the step count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= steps;
			end else if (run_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// remainder and quotient shift registers
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= rem_init;
			dvd_q <= dividend;
			dsr_q <= divisor;
			quo_q <= '0;
		end else if (run_q) begin
			rem_q <= fits ? diff[15:0] : trial[15:0];
			dvd_q <= {dvd_q[30:0], 1'b0};
			quo_q <= {quo_q[30:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ----- src/bai_datapath.sv -----
// table memory, scan, target and weight arithmetic, config and result registers
module bai_datapath #(
	parameter int MAX_BEAMS = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  bai_pkg::dp_ctl_t   ctl,
	output bai_pkg::dp_stat_t  stat,
	input  logic [1:0]         cmd,
	input  logic [9:0]         slot,
	input  logic signed [15:0] altitude,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [14:0]        cfg_data,
	output logic               done,
	output logic               valid_res,
	output logic [4:0]         lower_index,
	output logic [4:0]         upper_index,
	output logic [16:0]        weight,
	output logic signed [15:0] target_alt,
	output logic               orig_flag
);
	import bai_pkg::*;

	localparam int AW = (MAX_BEAMS > 1) ? $clog2(MAX_BEAMS) : 1;
	localparam int NW = $clog2(MAX_BEAMS + 1);

	// configuration
	logic [5:0]  beam_count_q;
	logic [10:0] out_beams_q;
	logic        preserve_q;
	logic [14:0] tol_q;

	// table memory
	logic signed [15:0] table_mem [MAX_BEAMS];
	logic signed [15:0] rd_data_q;
	logic [AW-1:0]      rd_addr;
	logic               mem_we;

	// item registers
	logic               gen_q;
	logic [9:0]         slot_q;
	logic signed [15:0] tgt_q;
	logic signed [15:0] first_q;
	logic signed [16:0] range_q;
	logic [25:0]        prod_q;

	// scan registers
	logic [NW-1:0] si_q;
	logic          ev_q;
	logic [AW-1:0] ev_idx_q;
	logic          found_q;
	logic [AW-1:0] uidx_q;
	logic          match_q;
	logic [AW-1:0] midx_q;
	logic [AW-1:0] lo_q;
	logic [AW-1:0] hi_q;

	// weight registers
	logic signed [15:0] tl_q;
	logic signed [17:0] num_q;
	logic signed [16:0] den_q;
	logic [16:0]        w_q;

	// result registers
	logic               done_q;
	logic               valid_res_q;
	logic [4:0]         lower_q;
	logic [4:0]         upper_q;
	logic [16:0]        weight_q;
	logic signed [15:0] target_q;
	logic               orig_q;

	logic [8:0]         bc_ext;
	logic [8:0]         n_ext;
	logic [NW-1:0]      n;
	logic [10:0]        gden;
	logic [27:0]        gnum;
	logic signed [16:0] d_raw;
	logic signed [17:0] n_raw;
	logic signed [16:0] sdiff;
	logic [16:0]        adiff;
	logic               need_div;
	logic               snap;
	logic [AW-1:0]      lo_sel;
	logic [8:0]         lo_ext;
	logic [8:0]         hi_ext;
	logic               div_start;
	logic [15:0]        div_rem;
	logic [31:0]        div_dvd;
	logic [15:0]        div_dsr;
	logic [5:0]         div_steps;
	logic               div_done;
	logic [31:0]        div_quo;

	// entries in use, clamped to 2..MAX_BEAMS
	always_comb begin
		bc_ext = {3'b000, beam_count_q};
		if (bc_ext < 9'd2) begin
			n_ext = 9'd2;
		end else if (bc_ext > 9'(MAX_BEAMS)) begin
			n_ext = 9'(MAX_BEAMS);
		end else begin
			n_ext = bc_ext;
		end
		n = n_ext[NW-1:0];
	end

	// configuration write port
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beam_count_q <= RST_BEAM_COUNT;
			out_beams_q  <= RST_OUTPUT_BEAMS;
			preserve_q   <= RST_PRESERVE;
			tol_q        <= RST_TOLERANCE;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_BEAM_COUNT:   beam_count_q <= cfg_data[5:0];
				CFG_OUTPUT_BEAMS: out_beams_q  <= cfg_data[10:0];
				CFG_PRESERVE:     preserve_q   <= cfg_data[0];
				CFG_TOLERANCE:    tol_q        <= cfg_data;
				default: ;
			endcase
		end
	end

	// table read address
	always_comb begin
		case (ctl.rd_sel)
			RD_FIRST: rd_addr = '0;
			RD_LAST:  rd_addr = AW'(n - NW'(1));
			RD_SCAN:  rd_addr = si_q[AW-1:0];
			RD_LO:    rd_addr = lo_q;
			RD_HI:    rd_addr = hi_q;
			default:  rd_addr = '0;
		endcase
	end

	assign mem_we = ctl.cap_in && (cmd == CMD_LOAD) && (11'(slot) < 11'(MAX_BEAMS));

	// table memory, one write and one registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			table_mem[slot[AW-1:0]] <= altitude;
		end
		rd_data_q <= table_mem[rd_addr];
	end

	// generate target arithmetic
	always_comb begin
		gden = (out_beams_q < 11'd2) ? 11'd1 : out_beams_q - 11'd1;
		gnum = {1'b0, prod_q, 1'b0} + 28'(gden);
	end

	always_ff @(posedge clk) begin
		if (ctl.cap_in) begin
			gen_q  <= (cmd == CMD_GEN);
			slot_q <= slot;
			tgt_q  <= altitude;
		end else if (ctl.set_gen_tgt) begin
			tgt_q <= first_q + div_quo[15:0];
		end
		if (ctl.cap_first) begin
			first_q <= rd_data_q;
		end
		if (ctl.calc_range) begin
			range_q <= 17'(rd_data_q) - 17'(first_q);
		end
		if (ctl.mul_go) begin
			prod_q <= 26'(slot_q) * 26'(range_q[15:0]);
		end
	end

	// scan compare of one entry against the target
	always_comb begin
		sdiff = 17'(rd_data_q) - 17'(tgt_q);
		adiff = sdiff[16] ? 17'(-sdiff) : 17'(sdiff);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			si_q    <= '0;
			ev_q    <= 1'b0;
			found_q <= 1'b0;
			match_q <= 1'b0;
		end else begin
			ev_q <= ctl.scan_step;
			if (ctl.scan_init) begin
				si_q    <= '0;
				found_q <= 1'b0;
				match_q <= 1'b0;
			end else begin
				if (ctl.scan_step) begin
					si_q <= si_q + NW'(1);
				end
				if (ev_q && !found_q && (rd_data_q > tgt_q)) begin
					found_q <= 1'b1;
				end
				if (ev_q && !match_q && (adiff < {2'b00, tol_q})) begin
					match_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		ev_idx_q <= si_q[AW-1:0];
		if (ev_q && !found_q && (rd_data_q > tgt_q)) begin
			uidx_q <= ev_idx_q;
		end
		if (ev_q && !match_q && (adiff < {2'b00, tol_q})) begin
			midx_q <= ev_idx_q;
		end
	end

	// bracketing pair from the scan outcome
	always_ff @(posedge clk) begin
		if (ctl.brk) begin
			if (!found_q) begin
				lo_q <= AW'(n - NW'(2));
				hi_q <= AW'(n - NW'(1));
			end else if (uidx_q == '0) begin
				lo_q <= '0;
				hi_q <= AW'(1);
			end else begin
				lo_q <= uidx_q - AW'(1);
				hi_q <= uidx_q;
			end
		end
	end

	// weight numerator and denominator, sign folded so the denominator is not negative
	always_comb begin
		d_raw    = 17'(rd_data_q) - 17'(tl_q);
		n_raw    = 18'(tgt_q) - 18'(tl_q);
		need_div = (den_q != '0) && (num_q > 18'sd0) && (num_q < 18'(den_q));
	end

	always_ff @(posedge clk) begin
		if (ctl.cap_tl) begin
			tl_q <= rd_data_q;
		end
		if (ctl.wt_prep) begin
			den_q <= d_raw[16] ? -d_raw : d_raw;
			num_q <= d_raw[16] ? -n_raw : n_raw;
		end
		if (ctl.wt_eval) begin
			if (den_q == '0) begin
				w_q <= WEIGHT_HALF;
			end else if (num_q <= 18'sd0) begin
				w_q <= WEIGHT_ZERO;
			end else if (num_q >= 18'(den_q)) begin
				w_q <= WEIGHT_ONE;
			end
		end else if (ctl.wt_div_done) begin
			w_q <= {1'b0, div_quo[15:0]};
		end
	end

	// divider operands: generate target or weight fraction
	always_comb begin
		div_start = ctl.gen_div_go || (ctl.wt_eval && need_div);
		if (ctl.gen_div_go) begin
			div_rem   = '0;
			div_dvd   = {gnum, 4'b0000};
			div_dsr   = {4'b0000, gden, 1'b0};
			div_steps = DIV_STEPS_GEN;
		end else begin
			div_rem   = num_q[15:0];
			div_dvd   = '0;
			div_dsr   = den_q[15:0];
			div_steps = DIV_STEPS_WT;
		end
	end

	bai_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.rem_init (div_rem),
		.dividend (div_dvd),
		.divisor  (div_dsr),
		.steps    (div_steps),
		.done     (div_done),
		.quotient (div_quo)
	);

	// snapping to an original entry
	always_comb begin
		snap   = gen_q && preserve_q && match_q;
		lo_sel = snap ? midx_q : lo_q;
		lo_ext = 9'(lo_sel);
		hi_ext = 9'(hi_q);
	end

	// result register and strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= ctl.emit || ctl.emit_bad;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.emit) begin
			valid_res_q <= 1'b1;
			lower_q     <= lo_ext[4:0];
			upper_q     <= hi_ext[4:0];
			weight_q    <= snap ? WEIGHT_ZERO : w_q;
			target_q    <= tgt_q;
			orig_q      <= snap;
		end else if (ctl.emit_bad) begin
			valid_res_q <= 1'b0;
			lower_q     <= '0;
			upper_q     <= '0;
			weight_q    <= WEIGHT_ZERO;
			target_q    <= '0;
			orig_q      <= 1'b0;
		end
	end

	// status to the controller
	always_comb begin
		stat.gen_bad     = ({1'b0, slot_q} >= out_beams_q) || (range_q <= 17'sd0);
		stat.scan_last   = (si_q == n - NW'(1));
		stat.div_done    = div_done;
		stat.wt_need_div = need_div;
	end

	assign done        = done_q;
	assign valid_res   = valid_res_q;
	assign lower_index = lower_q;
	assign upper_index = upper_q;
	assign weight      = weight_q;
	assign target_alt  = target_q;
	assign orig_flag   = orig_q;

endmodule

// ----- src/bai_ctrl.sv -----
// sequencing state machine of the altitude interpolator
module bai_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [1:0]        cmd,
	output logic              busy,
	output bai_pkg::dp_ctl_t  ctl,
	input  bai_pkg::dp_stat_t stat
);
	import bai_pkg::*;

	state_t state_q;
	state_t state_nxt;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// next state and datapath commands
	always_comb begin
		state_nxt  = state_q;
		ctl        = '0;
		ctl.rd_sel = RD_FIRST;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					ctl.cap_in = 1'b1;
					if (cmd == CMD_QUERY) begin
						ctl.scan_init = 1'b1;
						state_nxt     = ST_SCAN;
					end else if (cmd == CMD_GEN) begin
						state_nxt = ST_G_RD0;
					end
				end
			end
			ST_G_RD0: begin
				ctl.rd_sel = RD_FIRST;
				state_nxt  = ST_G_RD1;
			end
			ST_G_RD1: begin
				ctl.rd_sel    = RD_LAST;
				ctl.cap_first = 1'b1;
				state_nxt     = ST_G_RANGE;
			end
			ST_G_RANGE: begin
				ctl.calc_range = 1'b1;
				state_nxt      = ST_G_CHK;
			end
			ST_G_CHK: begin
				if (stat.gen_bad) begin
					ctl.emit_bad = 1'b1;
					state_nxt    = ST_IDLE;
				end else begin
					ctl.mul_go = 1'b1;
					state_nxt  = ST_G_DIV;
				end
			end
			ST_G_DIV: begin
				ctl.gen_div_go = 1'b1;
				state_nxt      = ST_G_WAIT;
			end
			ST_G_WAIT: begin
				if (stat.div_done) begin
					ctl.set_gen_tgt = 1'b1;
					ctl.scan_init   = 1'b1;
					state_nxt       = ST_SCAN;
				end
			end
			ST_SCAN: begin
				ctl.rd_sel    = RD_SCAN;
				ctl.scan_step = 1'b1;
				if (stat.scan_last) begin
					state_nxt = ST_FLUSH;
				end
			end
			ST_FLUSH: begin
				state_nxt = ST_BRK;
			end
			ST_BRK: begin
				ctl.brk   = 1'b1;
				state_nxt = ST_RD_LO;
			end
			ST_RD_LO: begin
				ctl.rd_sel = RD_LO;
				state_nxt  = ST_RD_HI;
			end
			ST_RD_HI: begin
				ctl.rd_sel = RD_HI;
				ctl.cap_tl = 1'b1;
				state_nxt  = ST_WT_PREP;
			end
			ST_WT_PREP: begin
				ctl.wt_prep = 1'b1;
				state_nxt   = ST_WT_CHK;
			end
			ST_WT_CHK: begin
				ctl.wt_eval = 1'b1;
				state_nxt   = stat.wt_need_div ? ST_WT_DIV : ST_OUT;
			end
			ST_WT_DIV: begin
				if (stat.div_done) begin
					ctl.wt_div_done = 1'b1;
					state_nxt       = ST_OUT;
				end
			end
			ST_OUT: begin
				ctl.emit  = 1'b1;
				state_nxt = ST_IDLE;
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	assign busy = (state_q != ST_IDLE);

endmodule

// ----- src/beam_altitude_interpolator_core.sv -----
// Beam altitude interpolator: a table of up to MAX_BEAMS ascending Q2.14
// altitudes, loaded one word at a time, that brackets a target altitude and
// returns the lower and upper entry indices with a Q1.16 weight; a generate
// word first forms the uniformly spaced target of one output beam and may
// snap to an original entry within the match tolerance. A word is taken
// when start is high and busy is low. A load gives no result. The next
// word can be taken in the cycle that shows the result. The scan reads one
// table entry per cycle through the single read port of the table, and the
// shared divider yields one quotient bit per cycle (16 for the weight, 28
// for the generate target). Each result shows for exactly one cycle with
// done high and cannot be held off. The user must write configuration
// through cfg_valid/cfg_index/cfg_data only while no word is in flight; the
// block itself does not enforce this. cfg_ready is always high. The table
// is not cleared at reset.
module beam_altitude_interpolator_core #(
	parameter int MAX_BEAMS = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         cmd,
	input  logic [9:0]         slot,
	input  logic signed [15:0] altitude,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [14:0]        cfg_data,
	output logic               done,
	output logic               valid_res,
	output logic [4:0]         lower_index,
	output logic [4:0]         upper_index,
	output logic [16:0]        weight,
	output logic signed [15:0] target_alt,
	output logic               orig_flag
);
	import bai_pkg::*;

	dp_ctl_t  ctl;
	dp_stat_t stat;

	// sequencer
	bai_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.cmd    (cmd),
		.busy   (busy),
		.ctl    (ctl),
		.stat   (stat)
	);

	// table, arithmetic and result registers
	bai_datapath #(
		.MAX_BEAMS (MAX_BEAMS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl),
		.stat        (stat),
		.cmd         (cmd),
		.slot        (slot),
		.altitude    (altitude),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.done        (done),
		.valid_res   (valid_res),
		.lower_index (lower_index),
		.upper_index (upper_index),
		.weight      (weight),
		.target_alt  (target_alt),
		.orig_flag   (orig_flag)
	);

endmodule

// ----- src/bai_port_checker.sv -----
// port-level checks of the altitude interpolator, bound to the top level
`include "beam_altitude_interpolator_core_macros.svh"

module bai_port_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic [1:0]         cmd,
	input logic               done,
	input logic               valid_res,
	input logic [4:0]         lower_index,
	input logic [4:0]         upper_index,
	input logic [16:0]        weight,
	input logic signed [15:0] target_alt,
	input logic               orig_flag
);
	import bai_pkg::*;

	// a query or generate word keeps the block busy on the next cycle
	`BAI_ASSERT_CLK(a_busy_after_work, clk, arst_n, start && !busy && (cmd == CMD_QUERY || cmd == CMD_GEN) |=> busy, "no busy after query or generate word")
	// a load or unknown word leaves the block free
	`BAI_ASSERT_CLK(a_free_after_load, clk, arst_n, start && !busy && (cmd == CMD_LOAD || cmd == CMD_NONE) |=> !busy, "busy after load word")
	// never two result strobes in a row
	`BAI_ASSERT_CLK(a_single_strobe, clk, arst_n, done |=> !done, "result strobe held for two cycles")
	// an invalid result carries all-zero fields
	`BAI_ASSERT_NEVER(a_invalid_zero, clk, arst_n, done && !valid_res && (lower_index != 5'd0 || upper_index != 5'd0 || weight != 17'd0 || target_alt != 16'sd0 || orig_flag), "invalid result with non-zero fields")
	// a snapped result has zero weight and the weight never exceeds one
	`BAI_ASSERT_NEVER(a_weight_range, clk, arst_n, done && ((orig_flag && weight != 17'd0) || weight > WEIGHT_ONE), "weight out of range")

endmodule

bind beam_altitude_interpolator_core bai_port_checker u_port_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.cmd         (cmd),
	.done        (done),
	.valid_res   (valid_res),
	.lower_index (lower_index),
	.upper_index (upper_index),
	.weight      (weight),
	.target_alt  (target_alt),
	.orig_flag   (orig_flag)
);

// ----- verif/beam_altitude_interpolator_core_test.sv -----
`timescale 1ns / 1ps
// testbench of the beam altitude interpolator: loads, queries and generates checked against a predictor
module beam_altitude_interpolator_core_test;
	import bai_pkg::*;

	localparam int TABLE_DEPTH = 32;
	localparam int DRAIN_CYCLES = 150;
	localparam int WORDS_WANTED = 1150;
	localparam int SESSION_WORDS = 40;

	// one result word as it leaves the block
	typedef struct packed {
		logic        valid;
		logic [4:0]  lower;
		logic [4:0]  upper;
		logic [16:0] weight;
		logic [15:0] target;
		logic        original;
	} beam_result_t;

	// altitude table, register copy and the queue of results still owed
	class altitude_scoreboard;
		int           alt_tab[TABLE_DEPTH];
		logic [5:0]   beam_count;
		logic [10:0]  out_beams;
		logic         preserve;
		logic [14:0]  tolerance;
		beam_result_t owed_results[$];
		int           mismatches;

		function new();
			foreach (alt_tab[i]) alt_tab[i] = 0;
			beam_count = RST_BEAM_COUNT;
			out_beams = RST_OUTPUT_BEAMS;
			preserve = RST_PRESERVE;
			tolerance = RST_TOLERANCE;
			mismatches = 0;
		endfunction

		function int entries_in_use();
			if (int'(beam_count) < 2) return 2;
			if (int'(beam_count) > TABLE_DEPTH) return TABLE_DEPTH;
			return int'(beam_count);
		endfunction

		function int outstanding();
			return owed_results.size();
		endfunction

		// bracketing pair and clamped q1.16 weight for one target
		function void bracket_target(input int x, output int lo, output int hi, output int w);
			int n;
			bit found;
			longint num, den;
			n = entries_in_use();
			lo = 0;
			hi = 0;
			found = 1'b0;
			for (int i = 0; i < n && !found; i++) begin
				if (alt_tab[i] <= x) lo = i;
				else begin
					hi = i;
					found = 1'b1;
				end
			end
			if (!found) begin
				lo = n - 2;
				hi = n - 1;
			end else if (hi == 0) begin
				lo = 0;
				hi = 1;
			end
			num = longint'(x) - longint'(alt_tab[lo]);
			den = longint'(alt_tab[hi]) - longint'(alt_tab[lo]);
			if (den == 0) w = int'(WEIGHT_HALF);
			else begin
				if (den < 0) begin
					den = -den;
					num = -num;
				end
				if (num <= 0) w = int'(WEIGHT_ZERO);
				else if (num >= den) w = int'(WEIGHT_ONE);
				else w = int'((num <<< 16) / den);
			end
		endfunction

		function void note_config(logic [1:0] idx, logic [14:0] data);
			case (idx)
				CFG_BEAM_COUNT:   beam_count = data[5:0];
				CFG_OUTPUT_BEAMS: out_beams = data[10:0];
				CFG_PRESERVE:     preserve = data[0];
				CFG_TOLERANCE:    tolerance = data;
				default: ;
			endcase
		endfunction

		// accepted word: update the table or work out the result it owes
		function void note_word(cmd_t c, logic [9:0] s, logic signed [15:0] a);
			beam_result_t r;
			int n, lo, hi, w, tgt, d;
			longint span, div;
			r = '0;
			case (c)
				CMD_LOAD: if (int'(s) < TABLE_DEPTH) alt_tab[s] = int'(a);
				CMD_QUERY: begin
					bracket_target(int'(a), lo, hi, w);
					r.valid = 1'b1;
					r.lower = 5'(lo);
					r.upper = 5'(hi);
					r.weight = 17'(w);
					r.target = a;
					owed_results.insert(owed_results.size(), r);
				end
				CMD_GEN: begin
					n = entries_in_use();
					span = longint'(alt_tab[n - 1]) - longint'(alt_tab[0]);
					div = (int'(out_beams) < 2) ? 64'sd1 : longint'(out_beams) - 1;
					if (int'(s) < int'(out_beams) && span > 0) begin
						tgt = alt_tab[0] + int'((2 * longint'(s) * span + div) / (2 * div));
						bracket_target(tgt, lo, hi, w);
						// snap to the first original entry within tolerance
						if (preserve) begin
							for (int k = 0; k < n && !r.original; k++) begin
								d = alt_tab[k] - tgt;
								if (d < 0) d = -d;
								if (d < int'(tolerance)) begin
									r.original = 1'b1;
									lo = k;
									w = 0;
								end
							end
						end
						r.valid = 1'b1;
						r.lower = 5'(lo);
						r.upper = 5'(hi);
						r.weight = 17'(w);
						r.target = 16'(tgt);
					end
					owed_results.insert(owed_results.size(), r);
				end
				default: ;
			endcase
		endfunction

		function void check_field(string name, int exp, int got);
			if (exp != got) begin
				$error("%s: expected %0d, got %0d", name, exp, got);
				mismatches++;
			end
		endfunction

		function void check_result(beam_result_t got);
			beam_result_t exp;
			if (owed_results.size() == 0) begin
				$error("result word with no result owed");
				mismatches++;
				return;
			end
			exp = owed_results.pop_front();
			check_field("valid_res", int'(exp.valid), int'(got.valid));
			check_field("lower_index", int'(exp.lower), int'(got.lower));
			check_field("upper_index", int'(exp.upper), int'(got.upper));
			check_field("weight", int'(exp.weight), int'(got.weight));
			check_field("target_alt", int'($signed(exp.target)), int'($signed(got.target)));
			check_field("orig_flag", int'(exp.original), int'(got.original));
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic start, busy;
	cmd_t cmd;
	logic [9:0] slot;
	logic signed [15:0] altitude;
	logic cfg_valid, cfg_ready;
	logic [1:0] cfg_index;
	logic [14:0] cfg_data;
	logic done, valid_res, orig_flag;
	logic [4:0] lower_index, upper_index;
	logic [16:0] weight;
	logic signed [15:0] target_alt;

	altitude_scoreboard interp_book = new();

	int sender_idle_pct;
	int words_sent;
	int stim_tab[TABLE_DEPTH];
	int n_live;
	int beams_live;

	beam_altitude_interpolator_core DUT (.*);

	// clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// check the result word first, then note register writes and words taken
	always @(posedge clk) begin
		beam_result_t seen;
		if (arst_n) begin
			if (done) begin
				seen.valid = valid_res;
				seen.lower = lower_index;
				seen.upper = upper_index;
				seen.weight = weight;
				seen.target = target_alt;
				seen.original = orig_flag;
				interp_book.check_result(seen);
			end
			if (cfg_valid && cfg_ready) interp_book.note_config(cfg_index, cfg_data);
			if (start && !busy) interp_book.note_word(cmd, slot, altitude);
		end
	end

	// one word into the block, with random idle cycles ahead of it
	task automatic send_word(cmd_t c, int s, int a);
		int gap;
		gap = 0;
		while ($urandom_range(99) < sender_idle_pct) gap++;
		if (sender_idle_pct > 0 && $urandom_range(99) < 3) gap += $urandom_range(1, 100);
		if (gap > 0) begin
			start <= 1'b0;
			cmd <= cmd_t'($urandom_range(0, 3));
			slot <= 10'($urandom);
			altitude <= 16'($urandom);
			repeat (gap) @(negedge clk);
		end
		start <= 1'b1;
		cmd <= c;
		slot <= 10'(s);
		altitude <= 16'(a);
		do @(posedge clk); while (busy);
		@(negedge clk);
		if (c == CMD_LOAD && s < TABLE_DEPTH) stim_tab[s] = int'($signed(16'(a)));
		if (c == CMD_QUERY || c == CMD_GEN || (c == CMD_LOAD && s < TABLE_DEPTH))
			words_sent++;
	endtask

	// stop sending, wait for every owed result, then let the block go quiet
	task automatic settle();
		start <= 1'b0;
		while (interp_book.outstanding() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, int data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= 15'(data);
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
	endtask

	task automatic apply_settings(int bc, int ob, int keep, int tol);
		int nb;
		write_reg(CFG_BEAM_COUNT, bc);
		write_reg(CFG_OUTPUT_BEAMS, ob);
		write_reg(CFG_PRESERVE, keep);
		write_reg(CFG_TOLERANCE, tol);
		cfg_valid <= 1'b0;
		nb = bc & 63;
		n_live = (nb < 2) ? 2 : ((nb > TABLE_DEPTH) ? TABLE_DEPTH : nb);
		beams_live = ob & 2047;
	endtask

	// fill entries 0..n-1, mostly ascending, now and then flat, reversed or unordered
	task automatic load_table(int n);
		int vals[TABLE_DEPTH];
		int kind, step, base, t, j;
		kind = $urandom_range(99);
		for (int i = 0; i < n; i++) vals[i] = int'($urandom_range(0, 65535)) - 32768;
		if (kind < 15) begin
			step = $urandom_range(0, 65535 / (n - 1));
			base = int'($urandom_range(0, 65535 - step * (n - 1))) - 32768;
			for (int i = 0; i < n; i++) vals[i] = base + i * step;
		end else if (kind < 25) begin
			base = int'($urandom_range(0, 65495)) - 32768;
			for (int i = 0; i < n; i++) vals[i] = base + int'($urandom_range(0, 40));
		end else if (kind < 30) begin
			for (int i = 0; i < n; i++) vals[i] = vals[0];
		end else if (kind >= 85 && kind < 90) begin
			vals[0] = -32768;
			vals[1] = 32767;
		end
		// ascending sort, descending for the reversed kind
		if (kind >= 15 && kind < 95) begin
			for (int i = 1; i < n; i++) begin
				t = vals[i];
				j = i;
				while (j > 0 && ((kind < 90) ? (vals[j - 1] > t) : (vals[j - 1] < t))) begin
					vals[j] = vals[j - 1];
					j--;
				end
				vals[j] = t;
			end
		end
		for (int i = 0; i < n; i++) send_word(CMD_LOAD, i, vals[i]);
	endtask

	task automatic random_word();
		int pick, s, a, e;
		pick = $urandom_range(99);
		if (pick < 45) begin
			// query: inside the table span, on or next to an entry, or anywhere
			e = stim_tab[$urandom_range(0, n_live - 1)];
			s = $urandom_range(0, 3);
			if (s < 2)
				a = int'($urandom_range(stim_tab[0] + 32768, stim_tab[n_live - 1] + 32768)) - 32768;
			else if (s == 2) a = e + int'($urandom_range(0, 2)) - 1;
			else a = int'($urandom_range(0, 65535)) - 32768;
			send_word(CMD_QUERY, $urandom_range(0, 1023), a);
		end else if (pick < 90) begin
			if (beams_live > 0 && $urandom_range(99) < 85)
				s = $urandom_range(0, ((beams_live > 1024) ? 1024 : beams_live) - 1);
			else s = $urandom_range(0, 1023);
			send_word(CMD_GEN, s, $urandom_range(0, 65535));
		end else if (pick < 95) begin
			// words the block drops
			if ($urandom_range(1))
				send_word(CMD_LOAD, $urandom_range(TABLE_DEPTH, 1023), $urandom_range(0, 65535));
			else send_word(CMD_NONE, $urandom_range(0, 1023), $urandom_range(0, 65535));
		end else begin
			send_word(CMD_LOAD, $urandom_range(0, n_live - 1), $urandom_range(0, 65535));
		end
	endtask

	// one phase: new register settings, a fresh table, then a run of words
	task automatic run_session(int index);
		int bc, ob, keep, tol, r;
		settle();
		case (index)
			0: begin
				bc = 2; ob = 2; keep = 0; tol = 0;
			end
			1: begin
				bc = 32; ob = 1024; keep = 1; tol = 32767;
			end
			2: begin
				bc = 0; ob = 1; keep = 1; tol = 100;
			end
			3: begin
				bc = 63; ob = 2047; keep = 1; tol = 500;
			end
			4: begin
				bc = 1; ob = 0; keep = 0; tol = 29;
			end
			default: begin
				r = $urandom_range(99);
				if (r < 80) bc = $urandom_range(2, 32);
				else if (r < 85) bc = 2;
				else if (r < 90) bc = 32;
				else if (r < 95) bc = $urandom_range(0, 1);
				else bc = $urandom_range(33, 63);
				r = $urandom_range(99);
				if (r < 25) ob = (bc < 2) ? 2 : ((bc > TABLE_DEPTH) ? TABLE_DEPTH : bc);
				else if (r < 40) ob = $urandom_range(2, 8);
				else if (r < 80) ob = $urandom_range(2, 1024);
				else if (r < 88) ob = $urandom_range(0, 1);
				else ob = $urandom_range(0, 2047);
				keep = $urandom_range(0, 1);
				r = $urandom_range(99);
				if (r < 30) tol = $urandom_range(0, 64);
				else if (r < 40) tol = 0;
				else if (r < 50) tol = 32767;
				else if (r < 70) tol = $urandom_range(0, 2000);
				else tol = $urandom_range(0, 32767);
				// junk in the unused upper data bits now and then
				if ($urandom_range(7) == 0) begin
					bc += int'($urandom_range(0, 511)) << 6;
					ob += int'($urandom_range(0, 15)) << 11;
					keep += int'($urandom_range(0, 16383)) << 1;
				end
			end
		endcase
		apply_settings(bc, ob, keep, tol);
		load_table(n_live);
		repeat (SESSION_WORDS) random_word();
	endtask

	// reset, directed corners, then random phases
	initial begin
		int session;
		arst_n = 1'b0;
		start = 1'b0;
		cmd = CMD_LOAD;
		slot = '0;
		altitude = '0;
		cfg_valid = 1'b0;
		cfg_index = CFG_BEAM_COUNT;
		cfg_data = '0;
		sender_idle_pct = 0;
		words_sent = 0;
		foreach (stim_tab[i]) stim_tab[i] = 0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;

		// four entries with an equal first pair and the top altitude last
		apply_settings(4, 5, 1, 29);
		send_word(CMD_LOAD, 0, -20000);
		send_word(CMD_LOAD, 1, -20000);
		send_word(CMD_LOAD, 2, 100);
		send_word(CMD_LOAD, 3, 32767);
		send_word(CMD_LOAD, 1023, -32768);
		send_word(CMD_NONE, 1023, -1);
		// below the first entry, at the top, mid span and on an entry
		send_word(CMD_QUERY, 0, -32768);
		send_word(CMD_QUERY, 1023, 32767);
		send_word(CMD_QUERY, 512, 0);
		send_word(CMD_QUERY, 1, 100);
		// first and last beam snap to entries, beams past the count are invalid
		send_word(CMD_GEN, 0, 0);
		send_word(CMD_GEN, 4, 0);
		send_word(CMD_GEN, 2, 0);
		send_word(CMD_GEN, 5, 0);
		send_word(CMD_GEN, 1023, 0);

		session = 0;
		while (words_sent < WORDS_WANTED) begin
			if (words_sent < WORDS_WANTED / 3) sender_idle_pct = 37;
			else if (words_sent < 2 * WORDS_WANTED / 3) sender_idle_pct = 51;
			else sender_idle_pct = 0;
			run_session(session);
			session++;
		end
		settle();
		if (interp_book.mismatches == 0 && interp_book.outstanding() == 0)
			$display("beam_altitude_interpolator_core: match");
		else
			$display("beam_altitude_interpolator_core: mismatch");
		$finish;
	end

	// watchdog
	initial begin
		#30_000_000;
		$display("beam_altitude_interpolator_core: mismatch");
		$finish;
	end

endmodule
